### hw/rtl/sector_extent_allocator_core_assert.svh
// Assertion macros shared by the allocator checker.
`ifndef SECTOR_EXTENT_ALLOCATOR_CORE_ASSERT_SVH
`define SECTOR_EXTENT_ALLOCATOR_CORE_ASSERT_SVH

// Same-cycle implication, checked at every edge outside reset.
`define SEA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every edge outside reset.
`define SEA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/sea_pkg.sv
// Shared types, codes and operation list of the sector extent allocator.
`timescale 1ns / 1ps
package sea_pkg;

	localparam logic [7:0]  NUL_PTR    = 8'hFF;
	localparam logic [15:0] INVALID_ID = 16'h00FF;

	localparam logic [1:0] CMD_FORMAT = 2'd0;
	localparam logic [1:0] CMD_CREATE = 2'd1;
	localparam logic [1:0] CMD_DELETE = 2'd2;
	localparam logic [1:0] CMD_OPEN   = 2'd3;

	localparam logic [2:0] ST_OK            = 3'd0;
	localparam logic [2:0] ST_NOT_FORMATTED = 3'd1;
	localparam logic [2:0] ST_INVALID_ID    = 3'd2;
	localparam logic [2:0] ST_NO_SPACE      = 3'd3;
	localparam logic [2:0] ST_NOT_FOUND     = 3'd4;

	localparam logic [1:0] REG_SECTOR_BYTES = 2'd0;
	localparam logic [1:0] REG_DATA_START   = 2'd1;
	localparam logic [1:0] REG_TOTAL        = 2'd2;

	typedef struct packed {
		logic [1:0]  command;
		logic [15:0] item_id;
		logic [15:0] item_size;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] extent_start;
		logic [15:0] extent_bytes;
		logic [7:0]  node_slot;
	} out_item_t;

	typedef struct packed {
		logic [15:0] ident;
		logic [15:0] bytes;
		logic [15:0] start;
		logic [7:0]  next;
		logic [7:0]  prev;
	} node_rec_t;

	typedef enum logic [4:0] {
		DP_NOP, DP_LATCH, DP_FMT_WR, DP_RES_ERR, DP_FIND_INIT, DP_RD_CUR, DP_ADV,
		DP_RES_OPEN, DP_DEL_HOLD, DP_DEL_P, DP_DEL_PW, DP_DEL_X, DP_DEL_XW, DP_DEL_N,
		DP_DIV_SIZE, DP_NEED_SET, DP_EMPTY_FIT, DP_RD_HEAD, DP_HEAD_FIT, DP_SCAN_DIV,
		DP_END_SET, DP_LIM_FIT, DP_ALLOC, DP_ALLOC_R, DP_ALLOC_B, DP_ALLOC_BW,
		DP_ALLOC_A, DP_ALLOC_AW, DP_RES_CREATE, DP_OUT_LOAD
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic [2:0] st;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] command;
		logic       id_bad;
		logic       formatted;
		logic       free_ok;
		logic       list_ok;
		logic       cur_ok;
		logic       id_match;
		logic       prev_ok;
		logic       next_ok;
		logic       fmt_last;
		logic       div_done;
		logic       empty_fit;
		logic       head_fit;
		logic       lim_fit;
		logic       before_ok;
		logic       after_ok;
	} dp_stat_t;

endpackage

### hw/rtl/sea_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module sea_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
	input  logic [WIDTH-1:0]                      wdata,
	output logic [WIDTH-1:0]                      rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end else begin
			rdata <= mem[addr];
		end
	end
endmodule

### hw/rtl/sea_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module sea_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [16:0] dividend,
	input  logic [15:0] divisor,
	output logic        busy,
	output logic [16:0] quotient
);
	localparam int DIV_STEPS = 17;

	logic        busy_q;
	logic [4:0]  cnt_q;
	logic [16:0] rem_q;
	logic [16:0] quo_q;
	logic [15:0] dvs_q;
	logic [16:0] trial;
	logic [16:0] diff;
	logic        ge;

	assign trial = {rem_q[15:0], quo_q[16]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= 5'(cnt_q + 5'd1);
			if (cnt_q == 5'(DIV_STEPS - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff : trial;
			quo_q <= {quo_q[15:0], ge};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;
endmodule

### hw/rtl/sea_dp.sv
// Allocator datapath: registers, node RAM, divider and fit compares.
`timescale 1ns / 1ps
module sea_dp #(
	parameter int NODE_COUNT = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  sea_pkg::dp_cmd_t   cmd,
	output sea_pkg::dp_stat_t  stat,
	input  sea_pkg::in_item_t  in_data,
	output sea_pkg::out_item_t out_data,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data
);
	localparam int         AW       = NODE_COUNT > 1 ? $clog2(NODE_COUNT) : 1;
	localparam logic [7:0] NODE_LIM = 8'(NODE_COUNT);

	function automatic logic is_node(input logic [7:0] p);
		return p < NODE_LIM;
	endfunction

	logic [15:0] sb_q, ds_q, ts_q;
	logic        formatted_q;
	logic [7:0]  list_head_q, free_head_q;
	sea_pkg::in_item_t  in_q;
	sea_pkg::node_rec_t rec_q;
	sea_pkg::out_item_t res_q, out_q;
	logic [7:0]  cur_q, steps_q, idx_q, before_q, after_q, slot_q;
	logic [16:0] need_q, end_q;
	logic [15:0] at_q;

	logic               ram_we;
	logic [7:0]         ram_ptr;
	sea_pkg::node_rec_t ram_wdata, ram_rdata;

	logic        div_start, div_busy;
	logic [15:0] div_bytes, sbe;
	logic [16:0] div_dividend, div_quo, lim;

	sea_ram #(.WIDTH($bits(sea_pkg::node_rec_t)), .DEPTH(NODE_COUNT)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_ptr[AW-1:0]),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	assign sbe          = (sb_q == 16'd0) ? 16'd1 : sb_q;
	assign div_bytes    = (cmd.op == sea_pkg::DP_SCAN_DIV) ? ram_rdata.bytes : in_q.item_size;
	assign div_dividend = 17'({1'b0, div_bytes} + {1'b0, sbe} - 17'd1);
	assign div_start    = (cmd.op == sea_pkg::DP_DIV_SIZE) || (cmd.op == sea_pkg::DP_SCAN_DIV);

	sea_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (sbe),
		.busy     (div_busy),
		.quotient (div_quo)
	);

	assign lim = is_node(rec_q.next) ? {1'b0, ram_rdata.start} : {1'b0, ts_q};

	always_comb begin
		stat.command   = in_q.command;
		stat.id_bad    = in_q.item_id == sea_pkg::INVALID_ID;
		stat.formatted = formatted_q;
		stat.free_ok   = is_node(free_head_q);
		stat.list_ok   = is_node(list_head_q);
		stat.cur_ok    = is_node(cur_q) && (steps_q < NODE_LIM);
		stat.id_match  = ram_rdata.ident == in_q.item_id;
		stat.prev_ok   = is_node(rec_q.prev);
		stat.next_ok   = is_node(rec_q.next);
		stat.fmt_last  = idx_q == 8'(NODE_COUNT - 1);
		stat.div_done  = !div_busy;
		stat.empty_fit = (ts_q >= ds_q) && ({1'b0, 16'(ts_q - ds_q)} >= need_q);
		stat.head_fit  = (ram_rdata.start > ds_q)
			&& ({1'b0, 16'(ram_rdata.start - ds_q)} >= need_q);
		stat.lim_fit   = (lim >= end_q) && (17'(lim - end_q) >= need_q);
		stat.before_ok = is_node(before_q);
		stat.after_ok  = is_node(after_q);
	end

	// Node RAM port: one read or one write per cycle.
	always_comb begin
		ram_we    = 1'b0;
		ram_ptr   = cur_q;
		ram_wdata = rec_q;
		case (cmd.op)
			sea_pkg::DP_FMT_WR: begin
				ram_we    = 1'b1;
				ram_ptr   = idx_q;
				ram_wdata = '0;
				ram_wdata.next = stat.fmt_last ? sea_pkg::NUL_PTR : 8'(idx_q + 8'd1);
				ram_wdata.prev = sea_pkg::NUL_PTR;
			end
			sea_pkg::DP_DEL_P:  ram_ptr = rec_q.prev;
			sea_pkg::DP_DEL_PW: begin
				ram_we    = 1'b1;
				ram_ptr   = rec_q.prev;
				ram_wdata = ram_rdata;
				ram_wdata.next = rec_q.next;
			end
			sea_pkg::DP_DEL_X:  ram_ptr = rec_q.next;
			sea_pkg::DP_DEL_XW: begin
				ram_we    = 1'b1;
				ram_ptr   = rec_q.next;
				ram_wdata = ram_rdata;
				ram_wdata.prev = rec_q.prev;
			end
			sea_pkg::DP_DEL_N: begin
				ram_we    = 1'b1;
				ram_wdata.next = free_head_q;
				ram_wdata.prev = sea_pkg::NUL_PTR;
			end
			sea_pkg::DP_RD_HEAD: ram_ptr = list_head_q;
			sea_pkg::DP_END_SET: ram_ptr = rec_q.next;
			sea_pkg::DP_ALLOC:   ram_ptr = free_head_q;
			sea_pkg::DP_ALLOC_R: begin
				ram_we    = 1'b1;
				ram_ptr   = slot_q;
				ram_wdata = '{ident: in_q.item_id, bytes: in_q.item_size, start: at_q,
					next: after_q, prev: before_q};
			end
			sea_pkg::DP_ALLOC_B:  ram_ptr = before_q;
			sea_pkg::DP_ALLOC_BW: begin
				ram_we    = 1'b1;
				ram_ptr   = before_q;
				ram_wdata = ram_rdata;
				ram_wdata.next = slot_q;
			end
			sea_pkg::DP_ALLOC_A:  ram_ptr = after_q;
			sea_pkg::DP_ALLOC_AW: begin
				ram_we    = 1'b1;
				ram_ptr   = after_q;
				ram_wdata = ram_rdata;
				ram_wdata.prev = slot_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sb_q        <= 16'd16;
			ds_q        <= 16'd1;
			ts_q        <= 16'hFFFF;
			formatted_q <= 1'b0;
			list_head_q <= sea_pkg::NUL_PTR;
			free_head_q <= sea_pkg::NUL_PTR;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					sea_pkg::REG_SECTOR_BYTES: sb_q <= cfg_data;
					sea_pkg::REG_DATA_START:   ds_q <= cfg_data;
					sea_pkg::REG_TOTAL:        ts_q <= cfg_data;
					default: ;
				endcase
			end
			case (cmd.op)
				sea_pkg::DP_FMT_WR: begin
					if (stat.fmt_last) begin
						list_head_q <= sea_pkg::NUL_PTR;
						free_head_q <= 8'd0;
						formatted_q <= 1'b1;
					end
				end
				sea_pkg::DP_DEL_P: begin
					if (!stat.prev_ok) begin
						list_head_q <= rec_q.next;
					end
				end
				sea_pkg::DP_DEL_N:   free_head_q <= cur_q;
				sea_pkg::DP_ALLOC_R: free_head_q <= ram_rdata.next;
				sea_pkg::DP_ALLOC_B: begin
					if (!stat.before_ok) begin
						list_head_q <= slot_q;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			sea_pkg::DP_LATCH: begin
				in_q  <= in_data;
				idx_q <= 8'd0;
			end
			sea_pkg::DP_FMT_WR:  idx_q <= 8'(idx_q + 8'd1);
			sea_pkg::DP_RES_ERR: res_q <= '{status: cmd.st, default: '0};
			sea_pkg::DP_FIND_INIT, sea_pkg::DP_RD_HEAD: begin
				cur_q   <= list_head_q;
				steps_q <= 8'd0;
			end
			sea_pkg::DP_ADV: begin
				cur_q   <= ram_rdata.next;
				steps_q <= 8'(steps_q + 8'd1);
			end
			sea_pkg::DP_RES_OPEN: res_q <= '{status: sea_pkg::ST_OK,
				extent_start: ram_rdata.start, extent_bytes: ram_rdata.bytes, node_slot: cur_q};
			sea_pkg::DP_DEL_HOLD: rec_q <= ram_rdata;
			sea_pkg::DP_DEL_N: res_q <= '{status: sea_pkg::ST_OK, extent_start: 16'd0,
				extent_bytes: 16'd0, node_slot: cur_q};
			sea_pkg::DP_NEED_SET: need_q <= div_quo;
			sea_pkg::DP_EMPTY_FIT: begin
				at_q     <= ds_q;
				before_q <= sea_pkg::NUL_PTR;
				after_q  <= sea_pkg::NUL_PTR;
			end
			sea_pkg::DP_HEAD_FIT: begin
				at_q     <= ds_q;
				before_q <= sea_pkg::NUL_PTR;
				after_q  <= list_head_q;
			end
			sea_pkg::DP_SCAN_DIV: rec_q <= ram_rdata;
			sea_pkg::DP_END_SET:  end_q <= 17'({1'b0, rec_q.start} + div_quo);
			sea_pkg::DP_LIM_FIT: begin
				at_q     <= end_q[15:0];
				before_q <= cur_q;
				after_q  <= rec_q.next;
				cur_q    <= rec_q.next;
				steps_q  <= 8'(steps_q + 8'd1);
			end
			sea_pkg::DP_ALLOC: slot_q <= free_head_q;
			sea_pkg::DP_RES_CREATE: res_q <= '{status: sea_pkg::ST_OK, extent_start: at_q,
				extent_bytes: in_q.item_size, node_slot: slot_q};
			sea_pkg::DP_OUT_LOAD: out_q <= res_q;
			default: ;
		endcase
	end

	assign out_data = out_q;
endmodule

### hw/rtl/sea_ctrl.sv
// Allocator controller: command sequencer and output handshake.
`timescale 1ns / 1ps
module sea_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output sea_pkg::dp_cmd_t  cmd,
	input  sea_pkg::dp_stat_t stat
);
	typedef enum logic [4:0] {
		S_IDLE, S_DISPATCH, S_FMT, S_FMT_END, S_FIND, S_FIND_CHK,
		S_DEL_P, S_DEL_PW, S_DEL_X, S_DEL_XW, S_DEL_N,
		S_NEED_W, S_LIST_CHK, S_HEAD_CHK, S_SCAN, S_SCAN_R, S_SCAN_W, S_SCAN_L,
		S_ALLOC, S_ALLOC_R, S_ALLOC_B, S_ALLOC_BW, S_ALLOC_A, S_ALLOC_AW,
		S_RES_C, S_DONE
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '{op: sea_pkg::DP_NOP, st: sea_pkg::ST_OK};
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = sea_pkg::DP_LATCH;
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				state_d = S_DONE;
				if (stat.command == sea_pkg::CMD_FORMAT) begin
					state_d = S_FMT;
				end else if (stat.command == sea_pkg::CMD_CREATE) begin
					if (stat.id_bad) begin
						cmd = '{op: sea_pkg::DP_RES_ERR, st: sea_pkg::ST_INVALID_ID};
					end else if (!stat.formatted) begin
						cmd = '{op: sea_pkg::DP_RES_ERR, st: sea_pkg::ST_NOT_FORMATTED};
					end else if (!stat.free_ok) begin
						cmd = '{op: sea_pkg::DP_RES_ERR, st: sea_pkg::ST_NO_SPACE};
					end else begin
						cmd.op  = sea_pkg::DP_DIV_SIZE;
						state_d = S_NEED_W;
					end
				end else if (!stat.formatted) begin
					cmd = '{op: sea_pkg::DP_RES_ERR, st: sea_pkg::ST_NOT_FORMATTED};
				end else begin
					cmd.op  = sea_pkg::DP_FIND_INIT;
					state_d = S_FIND;
				end
			end
			S_FMT: begin
				cmd.op = sea_pkg::DP_FMT_WR;
				if (stat.fmt_last) begin
					state_d = S_FMT_END;
				end
			end
			S_FMT_END: begin
				cmd     = '{op: sea_pkg::DP_RES_ERR, st: sea_pkg::ST_OK};
				state_d = S_DONE;
			end
			S_FIND: begin
				if (stat.cur_ok) begin
					cmd.op  = sea_pkg::DP_RD_CUR;
					state_d = S_FIND_CHK;
				end else begin
					cmd     = '{op: sea_pkg::DP_RES_ERR, st: sea_pkg::ST_NOT_FOUND};
					state_d = S_DONE;
				end
			end
			S_FIND_CHK: begin
				if (!stat.id_match) begin
					cmd.op  = sea_pkg::DP_ADV;
					state_d = S_FIND;
				end else if (stat.command == sea_pkg::CMD_OPEN) begin
					cmd.op  = sea_pkg::DP_RES_OPEN;
					state_d = S_DONE;
				end else begin
					cmd.op  = sea_pkg::DP_DEL_HOLD;
					state_d = S_DEL_P;
				end
			end
			S_DEL_P: begin
				cmd.op  = sea_pkg::DP_DEL_P;
				state_d = stat.prev_ok ? S_DEL_PW : S_DEL_X;
			end
			S_DEL_PW: begin
				cmd.op  = sea_pkg::DP_DEL_PW;
				state_d = S_DEL_X;
			end
			S_DEL_X: begin
				cmd.op  = sea_pkg::DP_DEL_X;
				state_d = stat.next_ok ? S_DEL_XW : S_DEL_N;
			end
			S_DEL_XW: begin
				cmd.op  = sea_pkg::DP_DEL_XW;
				state_d = S_DEL_N;
			end
			S_DEL_N: begin
				cmd.op  = sea_pkg::DP_DEL_N;
				state_d = S_DONE;
			end
			S_NEED_W: begin
				if (stat.div_done) begin
					cmd.op  = sea_pkg::DP_NEED_SET;
					state_d = S_LIST_CHK;
				end
			end
			S_LIST_CHK: begin
				if (stat.list_ok) begin
					cmd.op  = sea_pkg::DP_RD_HEAD;
					state_d = S_HEAD_CHK;
				end else if (stat.empty_fit) begin
					cmd.op  = sea_pkg::DP_EMPTY_FIT;
					state_d = S_ALLOC;
				end else begin
					cmd     = '{op: sea_pkg::DP_RES_ERR, st: sea_pkg::ST_NO_SPACE};
					state_d = S_DONE;
				end
			end
			S_HEAD_CHK: begin
				if (stat.head_fit) begin
					cmd.op  = sea_pkg::DP_HEAD_FIT;
					state_d = S_ALLOC;
				end else begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (stat.cur_ok) begin
					cmd.op  = sea_pkg::DP_RD_CUR;
					state_d = S_SCAN_R;
				end else begin
					cmd     = '{op: sea_pkg::DP_RES_ERR, st: sea_pkg::ST_NO_SPACE};
					state_d = S_DONE;
				end
			end
			S_SCAN_R: begin
				cmd.op  = sea_pkg::DP_SCAN_DIV;
				state_d = S_SCAN_W;
			end
			S_SCAN_W: begin
				if (stat.div_done) begin
					cmd.op  = sea_pkg::DP_END_SET;
					state_d = S_SCAN_L;
				end
			end
			S_SCAN_L: begin
				cmd.op  = sea_pkg::DP_LIM_FIT;
				state_d = stat.lim_fit ? S_ALLOC : S_SCAN;
			end
			S_ALLOC: begin
				cmd.op  = sea_pkg::DP_ALLOC;
				state_d = S_ALLOC_R;
			end
			S_ALLOC_R: begin
				cmd.op  = sea_pkg::DP_ALLOC_R;
				state_d = S_ALLOC_B;
			end
			S_ALLOC_B: begin
				cmd.op  = sea_pkg::DP_ALLOC_B;
				state_d = stat.before_ok ? S_ALLOC_BW : S_ALLOC_A;
			end
			S_ALLOC_BW: begin
				cmd.op  = sea_pkg::DP_ALLOC_BW;
				state_d = S_ALLOC_A;
			end
			S_ALLOC_A: begin
				cmd.op  = sea_pkg::DP_ALLOC_A;
				state_d = stat.after_ok ? S_ALLOC_AW : S_RES_C;
			end
			S_ALLOC_AW: begin
				cmd.op  = sea_pkg::DP_ALLOC_AW;
				state_d = S_RES_C;
			end
			S_RES_C: begin
				cmd.op  = sea_pkg::DP_RES_CREATE;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.op  = sea_pkg::DP_OUT_LOAD;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.op == sea_pkg::DP_OUT_LOAD) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;
endmodule

### hw/rtl/sector_extent_allocator_core.sv
// Top level of the sector extent allocator.
`timescale 1ns / 1ps
// First-fit allocator of sector extents over a table of NODE_COUNT nodes kept
// in a single-port RAM as a sorted doubly linked list plus a free list. Commands
// (format, create, delete, open) arrive on a valid/ready input channel; each
// one gives exactly one result on the output channel, held in an output
// register so the next command is taken while the last result still waits.
// Commands are handled one at a time. Format writes one RAM entry per node.
// Open and delete walk the list node by node; delete then relinks the
// neighbours of the node it frees. Create divides the size into sectors,
// then scans the list node by node, dividing each node's size in turn, and
// then links the new node in. The pace is set by the shared bit-serial
// divider and the single RAM port, which serves one read or one write per
// cycle. Node contents are not cleared at reset; only format chains nodes,
// and only the contents of chained nodes are ever used. Configuration
// writes (bytes per sector, data start, total sectors) take effect at once
// and must be made while no command is in progress.
module sector_extent_allocator_core #(
	parameter int NODE_COUNT = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  sea_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output sea_pkg::out_item_t out_data,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data
);
	sea_pkg::dp_cmd_t  cmd;
	sea_pkg::dp_stat_t stat;

	// Sequencer: walks each command through its steps, owns the handshakes.
	sea_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	// Datapath: node RAM, list heads, divider, compares and result registers.
	sea_dp #(.NODE_COUNT(NODE_COUNT)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_data   (in_data),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);
endmodule

### hw/rtl/sea_checker.sv
// Port-level checker for the sector extent allocator, bound to the top level.
`timescale 1ns / 1ps
`include "sector_extent_allocator_core_assert.svh"
module sea_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input sea_pkg::out_item_t out_data
);
	// A result that is not taken must hold.
	`SEA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result dropped or changed while stalled")

	// Failed commands report an empty extent and slot zero.
	`SEA_ASSERT_NOW(a_err_zero, out_valid && (out_data.status != sea_pkg::ST_OK), (out_data.extent_start == 16'd0) && (out_data.extent_bytes == 16'd0) && (out_data.node_slot == 8'd0), "error result carries extent data")

	// Status stays within the defined codes.
	`SEA_ASSERT_NOW(a_status_code, out_valid, out_data.status <= sea_pkg::ST_NOT_FOUND, "undefined status code")

	// One command at a time: the block is busy right after a transfer in.
	`SEA_ASSERT_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready, "second command taken while one is in progress")
endmodule

bind sector_extent_allocator_core sea_checker u_sea_checker (.*);
